@@ design/positional_ordered_list_assert.svh @@
// Assertion macros shared by the list block.
`ifndef POSITIONAL_ORDERED_LIST_ASSERT_SVH
`define POSITIONAL_ORDERED_LIST_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define POL_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition is followed in the next cycle by a consequence.
`define POL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/pol_pkg.sv @@
package pol_pkg;

  localparam int MODE_W   = 3;
  localparam int POS_W    = 8;
  localparam int STATUS_W = 3;

  typedef enum logic [MODE_W-1:0] {
    OP_CLEAR  = 3'd0,
    OP_APPEND = 3'd1,
    OP_INSERT = 3'd2,
    OP_FIND   = 3'd3,
    OP_DELETE = 3'd4,
    OP_DUMP   = 3'd5
  } op_t;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UNDEF    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd5;

  typedef struct packed {
    op_t               op;
    logic [POS_W-1:0]  position;
  } hdr_t;

endpackage

@@ design/pol_if.sv @@
interface pol_in_if
  import pol_pkg::*;
#(
  parameter int WORD_BITS = 32
);
  logic                        valid;
  logic                        ready;
  logic [MODE_W-1:0]           mode;
  logic [POS_W-1:0]            position;
  logic signed [WORD_BITS-1:0] value;

  modport source (output valid, mode, position, value, input ready);
  modport sink   (input valid, mode, position, value, output ready);
endinterface

interface pol_out_if
  import pol_pkg::*;
#(
  parameter int WORD_BITS = 32,
  parameter int IDX_W     = 5
);
  logic                        valid;
  logic                        ready;
  logic [STATUS_W-1:0]         status;
  logic [IDX_W-1:0]            index;
  logic signed [WORD_BITS-1:0] entry;
  logic                        last;

  modport source (output valid, status, index, entry, last, input ready);
  modport sink   (input valid, status, index, entry, last, output ready);
endinterface

@@ design/pol_front.sv @@
module pol_front
  import pol_pkg::*;
#(
  parameter int WORD_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  pol_in_if.sink                      cmd,
  output logic                        q_valid,
  input  logic                        q_ready,
  output hdr_t                        q_hdr,
  output logic signed [WORD_BITS-1:0] q_value
);

  logic                        fv;
  hdr_t                        fhdr;
  logic signed [WORD_BITS-1:0] fval;

  logic legal;
  op_t  op;

  always_comb begin
    legal = 1'b1;
    op    = OP_CLEAR;
    case (cmd.mode)
      OP_CLEAR:  op = OP_CLEAR;
      OP_APPEND: op = OP_APPEND;
      OP_INSERT: op = OP_INSERT;
      OP_FIND:   op = OP_FIND;
      OP_DELETE: op = OP_DELETE;
      OP_DUMP:   op = OP_DUMP;
      default:   legal = 1'b0;
    endcase
  end

  assign cmd.ready = !fv || q_ready;

  // drop unused modes here: they change nothing and answer nothing
  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (cmd.valid && cmd.ready) begin
      fv <= legal;
    end else if (q_ready) begin
      fv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      fhdr.op       <= op;
      fhdr.position <= cmd.position;
      fval          <= cmd.value;
    end
  end

  assign q_valid = fv;
  assign q_hdr   = fhdr;
  assign q_value = fval;

endmodule

@@ design/pol_queue.sv @@
module pol_queue
  import pol_pkg::*;
#(
  parameter int WORD_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push_valid,
  output logic                        push_ready,
  input  hdr_t                        push_hdr,
  input  logic signed [WORD_BITS-1:0] push_value,
  output logic                        pop_valid,
  input  logic                        pop_ready,
  output hdr_t                        pop_hdr,
  output logic signed [WORD_BITS-1:0] pop_value
);

  hdr_t                        qh [2];
  logic signed [WORD_BITS-1:0] qv [2];
  logic                        wr_ptr;
  logic                        rd_ptr;
  logic [1:0]                  fill;

  logic do_push;
  logic do_pop;

  assign push_ready = fill != 2'd2;
  assign pop_valid  = fill != 2'd0;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_hdr    = qh[rd_ptr];
  assign pop_value  = qv[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      qh[wr_ptr] <= push_hdr;
      qv[wr_ptr] <= push_value;
    end
  end

endmodule

@@ design/pol_back.sv @@
module pol_back
  import pol_pkg::*;
#(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  output logic                        q_ready,
  input  hdr_t                        q_hdr,
  input  logic signed [WORD_BITS-1:0] q_value,
  pol_out_if.source                   res
);

`include "positional_ordered_list_assert.svh"

  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DUMP = 2'b10
  } state_t;

  state_t                      state, state_next;
  logic [CW-1:0]               count, count_next;
  logic                        defined, defined_next;
  logic [CW-1:0]               ptr, ptr_next;
  logic signed [WORD_BITS-1:0] cells [DEPTH];
  logic signed [WORD_BITS-1:0] cells_next [DEPTH];

  logic                        o_valid;
  logic [STATUS_W-1:0]         o_status;
  logic [CW-1:0]               o_index;
  logic signed [WORD_BITS-1:0] o_entry;
  logic                        o_last;

  logic                        slot_free;
  logic                        take;
  logic                        load;
  logic [STATUS_W-1:0]         ld_status;
  logic [CW-1:0]               ld_index;
  logic signed [WORD_BITS-1:0] ld_entry;
  logic                        ld_last;

  logic [POS_W-1:0]            slot;
  logic [POS_W:0]              pos9;
  logic [POS_W:0]              cnt9;
  logic                        full;
  logic                        hit;
  logic [CW-1:0]               hit_idx;

  assign slot_free = !o_valid || res.ready;
  assign take      = (state == S_IDLE) && q_valid && slot_free;
  assign q_ready   = take;

  assign slot = (q_hdr.position <= POS_W'(1)) ? '0 : q_hdr.position - POS_W'(1);
  assign pos9 = {1'b0, q_hdr.position};
  assign cnt9 = (POS_W + 1)'(count);
  assign full = count == CW'(DEPTH);

  // first match wins: scan from the top so the lowest index is kept
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (CW'(i) < count && cells[i] == q_value) begin
        hit     = 1'b1;
        hit_idx = CW'(i + 1);
      end
    end
  end

  always_comb begin
    state_next   = state;
    count_next   = count;
    defined_next = defined;
    ptr_next     = ptr;
    cells_next   = cells;
    load         = 1'b0;
    ld_status    = ST_OK;
    ld_index     = '0;
    ld_entry     = '0;
    ld_last      = 1'b1;
    case (state)
      S_IDLE: begin
        if (take) begin
          load = 1'b1;
          if (q_hdr.op == OP_CLEAR) begin
            defined_next = 1'b1;
            count_next   = '0;
          end else if (!defined) begin
            ld_status = ST_UNDEF;
          end else begin
            case (q_hdr.op)
              OP_APPEND: begin
                if (full) begin
                  ld_status = ST_FULL;
                end else begin
                  for (int i = 0; i < DEPTH; i++) begin
                    if (CW'(i) == count) cells_next[i] = q_value;
                  end
                  count_next = count + CW'(1);
                  ld_index   = count + CW'(1);
                end
              end
              OP_INSERT: begin
                if (full) begin
                  ld_status = ST_FULL;
                end else if (pos9 > cnt9 + (POS_W + 1)'(1)) begin
                  ld_status = ST_BADPOS;
                end else begin
                  // open a gap at slot by shifting the tail up one cell
                  for (int i = 0; i < DEPTH; i++) begin
                    if (POS_W'(i) == slot) begin
                      cells_next[i] = q_value;
                    end else if (POS_W'(i) > slot && CW'(i) <= count) begin
                      cells_next[i] = cells[(i + DEPTH - 1) % DEPTH];
                    end
                  end
                  count_next = count + CW'(1);
                  ld_index   = CW'(slot) + CW'(1);
                end
              end
              OP_FIND: begin
                if (hit) begin
                  ld_index = hit_idx;
                end else begin
                  ld_status = ST_NOTFOUND;
                end
              end
              OP_DELETE: begin
                if (count == '0) begin
                  ld_status = ST_EMPTY;
                end else if ({1'b0, slot} >= cnt9) begin
                  ld_status = ST_BADPOS;
                end else begin
                  // close the gap by shifting the tail down one cell
                  for (int i = 0; i < DEPTH; i++) begin
                    if (POS_W'(i) >= slot && CW'(i) + CW'(1) < count) begin
                      cells_next[i] = cells[(i + 1) % DEPTH];
                    end
                  end
                  count_next = count - CW'(1);
                  ld_index   = CW'(slot) + CW'(1);
                end
              end
              OP_DUMP: begin
                if (count == '0) begin
                  ld_status = ST_EMPTY;
                end else begin
                  load       = 1'b0;
                  ptr_next   = '0;
                  state_next = S_DUMP;
                end
              end
              default: ld_status = ST_OK;
            endcase
          end
        end
      end
      S_DUMP: begin
        if (slot_free) begin
          load     = 1'b1;
          ld_index = ptr + CW'(1);
          ld_entry = cells[0];
          ld_last  = (ptr + CW'(1)) == count;
          // rotate the used cells so the next entry sits in cell 0;
          // once every entry has been sent the list is back in order
          for (int i = 0; i < DEPTH; i++) begin
            if (CW'(i) + CW'(1) == count) begin
              cells_next[i] = cells[0];
            end else if (CW'(i) < count) begin
              cells_next[i] = cells[(i + 1) % DEPTH];
            end
          end
          ptr_next = ptr + CW'(1);
          if (ld_last) state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      defined <= 1'b0;
      ptr     <= '0;
      o_valid <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      defined <= defined_next;
      ptr     <= ptr_next;
      if (load) begin
        o_valid <= 1'b1;
      end else if (res.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cells <= cells_next;
    if (load) begin
      o_status <= ld_status;
      o_index  <= ld_index;
      o_entry  <= ld_entry;
      o_last   <= ld_last;
    end
  end

  assign res.valid  = o_valid;
  assign res.status = o_status;
  assign res.index  = o_index;
  assign res.entry  = o_entry;
  assign res.last   = o_last;

  `POL_ASSERT(a_count_bound, clk, rst, count <= CW'(DEPTH), "count above depth")
  `POL_ASSERT(a_dump_list, clk, rst, state != S_DUMP || (defined && count != '0), "dump of no list")
  `POL_ASSERT(a_dump_ptr, clk, rst, state != S_DUMP || ptr < count, "dump pointer past tail")
  `POL_ASSERT_NEXT(a_clear, clk, rst, take && q_hdr.op == OP_CLEAR, defined && count == '0, "clear did not empty the list")

endmodule

@@ design/positional_ordered_list.sv @@
// Ordered list of up to DEPTH signed words, one operation per item: clear,
// append, insert at a 1-based position, find the first match, delete at a
// position, or dump. Every operation but dump answers with one item; a dump
// answers with one item per entry in list order, the final one marked last,
// or one empty or undefined status item. Modes 6 and 7 are dropped unanswered.
// Items pass a classifying register and a two-entry queue; the back end
// registers each result and retires one non-dump operation per cycle while
// its output is free and no dump runs, since insert, delete and find act on
// all cells at once. A dump first enters its dump state with no answer, then
// sends one entry per free cycle by rotating the cells through cell 0.
// Entries hold no reset value and need no clearing pass after reset.
module positional_ordered_list
  import pol_pkg::*;
#(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  pol_in_if.sink     cmd,
  pol_out_if.source  res
);

  logic                        f_valid;
  logic                        f_ready;
  hdr_t                        f_hdr;
  logic signed [WORD_BITS-1:0] f_value;
  logic                        b_valid;
  logic                        b_ready;
  hdr_t                        b_hdr;
  logic signed [WORD_BITS-1:0] b_value;

  pol_front #(.WORD_BITS(WORD_BITS)) u_front (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .q_valid (f_valid),
    .q_ready (f_ready),
    .q_hdr   (f_hdr),
    .q_value (f_value)
  );

  pol_queue #(.WORD_BITS(WORD_BITS)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_hdr   (f_hdr),
    .push_value (f_value),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_hdr    (b_hdr),
    .pop_value  (b_value)
  );

  pol_back #(.DEPTH(DEPTH), .WORD_BITS(WORD_BITS)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (b_valid),
    .q_ready (b_ready),
    .q_hdr   (b_hdr),
    .q_value (b_value),
    .res     (res)
  );

endmodule

@@ dv/positional_ordered_list_test.sv @@
`timescale 1ns / 1ps

module positional_ordered_list_test;
  import pol_pkg::*;

  localparam int DEPTH     = 16;
  localparam int WORD_BITS = 32;
  localparam int IDX_W     = 5;

  // Modes the block drops without an answer.
  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

  typedef struct {
    logic [STATUS_W-1:0]         status;
    logic [IDX_W-1:0]            index;
    logic signed [WORD_BITS-1:0] entry;
    logic                        last;
  } reply_t;

  class list_shadow;
    logic signed [WORD_BITS-1:0] cells[DEPTH];
    int                          count;
    bit                          defined;
    reply_t                      owed_replies[$];
    int                          mismatches;

    function new();
      count      = 0;
      defined    = 0;
      mismatches = 0;
    endfunction

    function void owe(logic [STATUS_W-1:0] status, int index,
                      logic signed [WORD_BITS-1:0] entry, logic last);
      reply_t r;
      r.status = status;
      r.index  = index[IDX_W-1:0];
      r.entry  = entry;
      r.last   = last;
      owed_replies.push_back(r);
    endfunction

    function void take_command(logic [MODE_W-1:0] mode, logic [POS_W-1:0] position,
                               logic signed [WORD_BITS-1:0] value);
      int slot;
      if (mode > OP_DUMP) return;
      if (mode == OP_CLEAR) begin
        defined = 1;
        count   = 0;
        owe(ST_OK, 0, 0, 1'b1);
        return;
      end
      if (!defined) begin
        owe(ST_UNDEF, 0, 0, 1'b1);
        return;
      end
      case (mode)
        OP_APPEND: begin
          if (count >= DEPTH) begin
            owe(ST_FULL, 0, 0, 1'b1);
          end else begin
            cells[count] = value;
            count++;
            owe(ST_OK, count, 0, 1'b1);
          end
        end
        OP_INSERT: begin
          if (count >= DEPTH) begin
            owe(ST_FULL, 0, 0, 1'b1);
          end else if (position > count + 1) begin
            owe(ST_BADPOS, 0, 0, 1'b1);
          end else begin
            slot = (position <= 1) ? 0 : position - 1;
            for (int i = count; i > slot; i--) cells[i] = cells[i-1];
            cells[slot] = value;
            count++;
            owe(ST_OK, slot + 1, 0, 1'b1);
          end
        end
        OP_FIND: begin
          slot = -1;
          for (int i = 0; i < count; i++)
            if (slot < 0 && cells[i] == value) slot = i;
          if (slot < 0) owe(ST_NOTFOUND, 0, 0, 1'b1);
          else owe(ST_OK, slot + 1, 0, 1'b1);
        end
        OP_DELETE: begin
          slot = (position <= 1) ? 0 : position - 1;
          if (count == 0) begin
            owe(ST_EMPTY, 0, 0, 1'b1);
          end else if (slot >= count) begin
            owe(ST_BADPOS, 0, 0, 1'b1);
          end else begin
            for (int i = slot; i + 1 < count; i++) cells[i] = cells[i+1];
            count--;
            owe(ST_OK, slot + 1, 0, 1'b1);
          end
        end
        default: begin
          if (count == 0) owe(ST_EMPTY, 0, 0, 1'b1);
          else
            for (int i = 0; i < count; i++)
              owe(ST_OK, i + 1, cells[i], i + 1 == count);
        end
      endcase
    endfunction

    function void check_reply(logic [STATUS_W-1:0] status, logic [IDX_W-1:0] index,
                              logic signed [WORD_BITS-1:0] entry, logic last);
      reply_t r;
      if (owed_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected reply: status %0d index %0d entry %0d last %0b",
                   status, index, entry, last);
        return;
      end
      r = owed_replies.pop_front();
      if (status !== r.status || index !== r.index || entry !== r.entry || last !== r.last)
      begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch (exp/act): status %0d/%0d index %0d/%0d entry %0d/%0d last %0b/%0b",
                   r.status, status, r.index, index, r.entry, entry, r.last, last);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   steady;
  int   issued;

  pol_in_if  #(.WORD_BITS(WORD_BITS))                 cmd_if ();
  pol_out_if #(.WORD_BITS(WORD_BITS), .IDX_W(IDX_W))  res_if ();

  positional_ordered_list #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_top (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if),
    .res (res_if)
  );

  list_shadow shadow = new();

  always #5 clk = ~clk;

  always @(negedge clk) begin
    res_if.ready <= steady || ($urandom_range(0, 99) >= 29);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cmd_if.valid && cmd_if.ready)
        shadow.take_command(cmd_if.mode, cmd_if.position, cmd_if.value);
      if (res_if.valid && res_if.ready)
        shadow.check_reply(res_if.status, res_if.index, res_if.entry, res_if.last);
    end
  end

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic issue(logic [MODE_W-1:0] mode, logic [POS_W-1:0] position,
                       logic signed [WORD_BITS-1:0] value);
    while (!steady && $urandom_range(0, 99) < 29) begin
      cmd_if.valid    <= 1'b0;
      cmd_if.mode     <= MODE_W'($urandom);
      cmd_if.position <= POS_W'($urandom);
      cmd_if.value    <= $urandom;
      @(negedge clk);
    end
    cmd_if.valid    <= 1'b1;
    cmd_if.mode     <= mode;
    cmd_if.position <= position;
    cmd_if.value    <= value;
    do @(posedge clk); while (!cmd_if.ready);
    @(negedge clk);
    if (mode <= OP_DUMP) issued++;
  endtask

  function automatic logic signed [WORD_BITS-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return -1;
      2: return 32'sh7fffffff;
      3: return 32'sh80000000;
      4: return $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  // Mostly in-range positions, with some beyond the tail and some fully random.
  function automatic logic [POS_W-1:0] pick_position(int span);
    if ($urandom_range(0, 99) < 15) return POS_W'($urandom);
    return POS_W'($urandom_range(0, span));
  endfunction

  task automatic fill_session();
    issue(OP_CLEAR, POS_W'($urandom), $urandom);
    repeat (DEPTH + 1) issue(OP_APPEND, POS_W'($urandom), pick_word());
    issue(OP_INSERT, pick_position(DEPTH + 1), pick_word());
    issue(OP_FIND, POS_W'($urandom), pick_word());
    issue(OP_DUMP, POS_W'($urandom), $urandom);
    repeat ($urandom_range(2, 5)) issue(OP_DELETE, pick_position(shadow.count), $urandom);
  endtask

  task automatic list_session();
    int r;
    if ($urandom_range(0, 2) == 0) issue(OP_CLEAR, POS_W'($urandom), $urandom);
    repeat ($urandom_range(6, 12)) begin
      r = $urandom_range(0, 99);
      if (r < 30)      issue(OP_APPEND, POS_W'($urandom), pick_word());
      else if (r < 50) issue(OP_INSERT, pick_position(shadow.count + 2), pick_word());
      else if (r < 65) issue(OP_FIND, POS_W'($urandom), pick_word());
      else if (r < 85) issue(OP_DELETE, pick_position(shadow.count + 1), $urandom);
      else if (r < 95) issue(OP_DUMP, POS_W'($urandom), $urandom);
      else if (r < 98) issue(OP_CLEAR, POS_W'($urandom), $urandom);
      else             issue(MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI)),
                             POS_W'($urandom), $urandom);
    end
  endtask

  task automatic noise_session();
    repeat ($urandom_range(1, 4)) issue(MODE_W'($urandom), POS_W'($urandom), $urandom);
  endtask

  initial begin
    clk             = 1'b0;
    rst             = 1'b1;
    steady          = 1'b0;
    issued          = 0;
    cmd_if.valid    = 1'b0;
    cmd_if.mode     = OP_CLEAR;
    cmd_if.position = '0;
    cmd_if.value    = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // no list yet
    issue(OP_APPEND, 8'd1, 32'sd5);
    issue(OP_INSERT, 8'd1, 32'sd5);
    issue(OP_FIND, 8'd0, 32'sd5);
    issue(OP_DELETE, 8'd1, 32'sd0);
    issue(OP_DUMP, 8'd0, 32'sd0);
    issue(MODE_SPARE_LO, 8'hff, -32'sd1);
    issue(MODE_SPARE_HI, 8'h00, 32'sd0);
    // empty list
    issue(OP_CLEAR, 8'd0, 32'sd0);
    issue(OP_DUMP, 8'd0, 32'sd0);
    issue(OP_FIND, 8'd0, 32'sd0);
    issue(OP_DELETE, 8'd1, 32'sd0);
    issue(OP_APPEND, 8'd0, 32'sh7fffffff);
    issue(OP_APPEND, 8'd0, 32'sh80000000);
    issue(OP_APPEND, 8'd0, -32'sd1);
    issue(OP_INSERT, 8'd0, 32'sd7);
    issue(OP_INSERT, 8'd1, 32'sd8);
    issue(OP_INSERT, 8'd6, 32'sd0);
    issue(OP_INSERT, 8'd8, 32'sd9);
    issue(OP_INSERT, 8'd255, 32'sd9);
    issue(OP_FIND, 8'd0, -32'sd1);
    issue(OP_FIND, 8'd0, 32'sd12345);
    issue(OP_DELETE, 8'd255, 32'sd0);
    issue(OP_DELETE, 8'd0, 32'sd0);
    issue(OP_DELETE, 8'd5, 32'sd0);
    issue(OP_DUMP, 8'd0, 32'sd0);
    issue(OP_CLEAR, 8'd0, 32'sd0);
    issue(OP_DUMP, 8'd0, 32'sd0);

    fill_session();
    while (issued < 160) begin
      // hold both sides busy for a stretch in the middle
      steady = (issued >= 60 && issued < 110);
      case ($urandom_range(0, 9))
        0:       noise_session();
        1:       fill_session();
        default: list_session();
      endcase
    end
    steady = 1'b0;
    cmd_if.valid <= 1'b0;

    while (shadow.owed_replies.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (shadow.mismatches == 0 && shadow.owed_replies.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
